// ===== design/fcw_pkg.sv =====
// Shared constants, codes and register defaults of the FAT12 cluster chain walker.
`default_nettype none
package fcw_pkg;

	// Field widths.
	localparam int CLUSTER_W = 12;
	localparam int STATUS_W  = 2;
	localparam int OFFSET_W  = 32;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 3;

	// Geometry register widths.
	localparam int SECTOR_W  = 13;
	localparam int CLUS_SEC_W = 8;
	localparam int RESV_W    = 16;
	localparam int COPIES_W  = 3;
	localparam int TSEC_W    = 8;
	localparam int ROOT_W    = 13;

	// Datapath widths.
	localparam int DIR_SHIFT = 5;                     // 32 bytes per root entry
	localparam int DIV_N_W   = ROOT_W + DIR_SHIFT;    // root directory bytes
	localparam int FATS_W    = COPIES_W + TSEC_W;     // copies times table sectors
	localparam int BASE_W    = 19;                    // first data sector
	localparam int MUL_A_W   = 21;
	localparam int MUL_B_W   = 13;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int CHAIN_W   = 20;                    // (cluster - 2) * sectors per cluster

	// Parameter defaults.
	localparam int FAT_ENTRIES_DEF = 4096;
	localparam int MAX_CHAIN_DEF   = 64;

	// Cluster markers.
	localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
	localparam logic [CLUSTER_W-1:0] BAD_MARK   = 12'hFF7;
	localparam logic [CLUSTER_W-1:0] FIRST_DATA = 12'd2;

	// Item modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_WALK = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_CLUSTER = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LONG    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_SECTOR_BYTES    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLUSTER_SECTORS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESERVED_COUNT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_COPIES    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_SECTORS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROOT_ENTRIES    = 3'd5;

	// Register reset values.
	localparam logic [SECTOR_W-1:0]   SECTOR_BYTES_RST    = 13'd512;
	localparam logic [CLUS_SEC_W-1:0] CLUSTER_SECTORS_RST = 8'd1;
	localparam logic [RESV_W-1:0]     RESERVED_COUNT_RST  = 16'd1;
	localparam logic [COPIES_W-1:0]   TABLE_COPIES_RST    = 3'd2;
	localparam logic [TSEC_W-1:0]     TABLE_SECTORS_RST   = 8'd9;
	localparam logic [ROOT_W-1:0]     ROOT_ENTRIES_RST    = 13'd224;

endpackage
`default_nettype wire

// ===== design/fcw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module fcw_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/fcw_ceil_div.sv =====
// Bit-serial restoring divider that returns the rounded-up quotient.
`default_nettype none
module fcw_ceil_div #(
	parameter int DW = 18,
	parameter int VW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] ceil_quo
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= VW'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// A zero divisor gives a zero quotient.
	assign ceil_quo = (dsr_q == '0) ? '0 : quo_q + DW'(rem_q != '0);

endmodule
`default_nettype wire

// ===== design/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: table store, sequencer and offset datapath.
//
// Usage. An item is taken at a rising edge with start high and busy low. With mode low
// the item writes entry_value into table entry entry_index (indexes past the table are
// dropped); it gives no result and busy stays low. With mode high the block walks the
// chain from head_cluster and emits one result beat per cluster on status,
// cluster_number, byte_offset and last, each marked by result_valid for exactly one
// cycle. The receiver cannot stall, so every beat must be taken when it appears.
// A start at the end marker gives one empty-chain beat in the next cycle and no busy.
// Geometry registers are written through cfg_we, cfg_index and cfg_data while idle.
// Sequence. A walk first runs the root directory sector count through the bit-serial
// divider, whose done flag leads to the base sector sum. Each cluster then uses the
// shared multiplier and the table read port in the steps check, table read with
// (cluster - 2) times sectors per cluster, base sector plus that times bytes per
// sector, and commit. A cluster beat leaves only once the following entry is known,
// since that sets its last flag. An error that follows a cluster beat comes from an
// extra error state after it.
// Reset clears the sequencer and loads the geometry defaults; the table contents are
// undefined until written and no clearing pass is made.
`default_nettype none
module fat12_cluster_chain_walker import fcw_pkg::*; #(
	parameter int FAT_ENTRIES = FAT_ENTRIES_DEF,
	parameter int MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 mode,
	input  wire logic [CLUSTER_W-1:0] entry_index,
	input  wire logic [CLUSTER_W-1:0] entry_value,
	input  wire logic [CLUSTER_W-1:0] head_cluster,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      result_valid,
	output logic      [STATUS_W-1:0]  status,
	output logic      [CLUSTER_W-1:0] cluster_number,
	output logic      [OFFSET_W-1:0]  byte_offset,
	output logic                      last
);

	localparam int AW    = $clog2(FAT_ENTRIES);
	localparam int CNT_W = $clog2(MAX_CHAIN + 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_BASE = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_MUL1 = 3'd4;
	localparam logic [2:0] S_MUL2 = 3'd5;
	localparam logic [2:0] S_MUL3 = 3'd6;
	localparam logic [2:0] S_ERR  = 3'd7;

	// Geometry registers.
	logic [SECTOR_W-1:0]   sector_bytes_q;
	logic [CLUS_SEC_W-1:0] cluster_sectors_q;
	logic [RESV_W-1:0]     reserved_count_q;
	logic [COPIES_W-1:0]   table_copies_q;
	logic [TSEC_W-1:0]     table_sectors_q;
	logic [ROOT_W-1:0]     root_entries_q;

	logic [2:0]           state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_valid_q;
	logic [CLUSTER_W-1:0] cur_q;
	logic [CLUSTER_W-1:0] next_q;
	logic [CLUSTER_W-1:0] pend_cluster_q;
	logic [OFFSET_W-1:0]  pend_off_q;
	logic [BASE_W-1:0]    base_q;
	logic [OFFSET_W-1:0]  mul_q;

	logic                 accept;
	logic                 idx_ok;
	logic                 ram_we;
	logic [CLUSTER_W-1:0] ram_rdata;
	logic                 div_go;
	logic                 div_done;
	logic [DIV_N_W-1:0]   root_sectors;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;
	logic                 cur_end;
	logic                 cur_bad;
	logic                 cnt_full;

	logic                 emit_v;
	logic [STATUS_W-1:0]  emit_st;
	logic [CLUSTER_W-1:0] emit_cl;
	logic [OFFSET_W-1:0]  emit_off;
	logic                 emit_last;

	assign accept   = start && !busy;
	assign busy     = state_q != S_IDLE;
	assign idx_ok   = {1'b0, entry_index} < (CLUSTER_W + 1)'(FAT_ENTRIES);
	assign cur_end  = cur_q >= END_MARK;
	assign cur_bad  = (cur_q == BAD_MARK) || (cur_q < FIRST_DATA)
		|| ({1'b0, cur_q} >= (CLUSTER_W + 1)'(FAT_ENTRIES));
	assign cnt_full = cnt_q == CNT_W'(MAX_CHAIN);

	// The allocation table: written by load items, read at the current cluster.
	fcw_ram #(
		.WIDTH(CLUSTER_W),
		.DEPTH(FAT_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(entry_index[AW-1:0]),
		.wdata(entry_value),
		.raddr(cur_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Root directory sectors: ceil(root_entries * 32 / sector_bytes).
	fcw_ceil_div #(
		.DW(DIV_N_W),
		.VW(SECTOR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend({root_entries_q, DIR_SHIFT'(0)}),
		.divisor (sector_bytes_q),
		.done    (div_done),
		.ceil_quo(root_sectors)
	);

	// The one shared multiplier; its product is registered every cycle.
	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_bytes_q    <= SECTOR_BYTES_RST;
			cluster_sectors_q <= CLUSTER_SECTORS_RST;
			reserved_count_q  <= RESERVED_COUNT_RST;
			table_copies_q    <= TABLE_COPIES_RST;
			table_sectors_q   <= TABLE_SECTORS_RST;
			root_entries_q    <= ROOT_ENTRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECTOR_BYTES: begin
					sector_bytes_q <= cfg_data[SECTOR_W-1:0];
				end
				REG_CLUSTER_SECTORS: begin
					cluster_sectors_q <= cfg_data[CLUS_SEC_W-1:0];
				end
				REG_RESERVED_COUNT: begin
					reserved_count_q <= cfg_data[RESV_W-1:0];
				end
				REG_TABLE_COPIES: begin
					table_copies_q <= cfg_data[COPIES_W-1:0];
				end
				REG_TABLE_SECTORS: begin
					table_sectors_q <= cfg_data[TSEC_W-1:0];
				end
				REG_ROOT_ENTRIES: begin
					root_entries_q <= cfg_data[ROOT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer. A visited cluster waits as the pending beat until the entry that
	// follows it is known: an end marker makes it the last beat, and an error on the
	// beat after the chain limit takes its place.
	always_comb begin
		state_d   = state_q;
		emit_v    = 1'b0;
		emit_st   = ST_CLUSTER;
		emit_cl   = pend_cluster_q;
		emit_off  = pend_off_q;
		emit_last = 1'b0;
		div_go    = 1'b0;
		ram_we    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_LOAD) begin
						ram_we = idx_ok;
					end else if (head_cluster >= END_MARK) begin
						emit_v    = 1'b1;
						emit_st   = ST_EMPTY;
						emit_cl   = head_cluster;
						emit_off  = '0;
						emit_last = 1'b1;
					end else begin
						div_go  = 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				// The table area product settles while the divider runs.
				mul_a = MUL_A_W'(table_copies_q);
				mul_b = MUL_B_W'(table_sectors_q);
				if (div_done) begin
					state_d = S_BASE;
				end
			end
			S_BASE: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (cur_end) begin
					emit_v    = 1'b1;
					emit_last = 1'b1;
					state_d   = S_IDLE;
				end else if (cur_bad) begin
					if (pend_valid_q && !cnt_full) begin
						emit_v  = 1'b1;
						state_d = S_ERR;
					end else begin
						emit_v    = 1'b1;
						emit_st   = ST_BAD;
						emit_cl   = cur_q;
						emit_off  = '0;
						emit_last = 1'b1;
						state_d   = S_IDLE;
					end
				end else if (cnt_full) begin
					emit_v    = 1'b1;
					emit_st   = ST_LONG;
					emit_cl   = cur_q;
					emit_off  = '0;
					emit_last = 1'b1;
					state_d   = S_IDLE;
				end else begin
					emit_v  = pend_valid_q;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				mul_a   = MUL_A_W'(cur_q - FIRST_DATA);
				mul_b   = MUL_B_W'(cluster_sectors_q);
				state_d = S_MUL2;
			end
			S_MUL2: begin
				mul_a   = MUL_A_W'(base_q) + MUL_A_W'(mul_q[CHAIN_W-1:0]);
				mul_b   = sector_bytes_q;
				state_d = S_MUL3;
			end
			S_MUL3: begin
				state_d = S_EVAL;
			end
			S_ERR: begin
				emit_v    = 1'b1;
				emit_st   = ST_BAD;
				emit_cl   = cur_q;
				emit_off  = '0;
				emit_last = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit_v;
			if (div_go) begin
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (state_q == S_MUL3) begin
				cnt_q        <= cnt_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_q          <= mul_p[OFFSET_W-1:0];
		status         <= emit_st;
		cluster_number <= emit_cl;
		byte_offset    <= emit_off;
		last           <= emit_last;
		if (state_q == S_IDLE) begin
			cur_q <= head_cluster;
		end else if (state_q == S_MUL3) begin
			cur_q <= next_q;
		end
		if (state_q == S_BASE) begin
			base_q <= BASE_W'(reserved_count_q) + BASE_W'(mul_q[FATS_W-1:0])
				+ BASE_W'(root_sectors);
		end
		if (state_q == S_EVAL) begin
			pend_cluster_q <= cur_q;
		end
		if (state_q == S_MUL1) begin
			next_q <= ram_rdata;
		end
		if (state_q == S_MUL3) begin
			pend_off_q <= mul_q;
		end
	end

`ifndef SYNTH
	// Every error or empty-chain beat closes its walk and carries no offset.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_CLUSTER) |-> last && (byte_offset == '0))
		else $error("error beat without last or with an offset");

	// The sequencer is back in idle by the time the last beat of a walk shows.
	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("last beat while the walk is still running");

	// The cluster count never passes the chain limit.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CHAIN))
		else $error("cluster count past the chain limit");

	// An item with no result never raises a beat in the following cycle.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == MODE_LOAD) |=> !result_valid)
		else $error("load item produced a result beat");
`endif

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the FAT12 cluster chain walker.
`timescale 1ns / 1ps

// The testbench drives load and walk items into the walker through its start/busy
// handshake and predicts every result beat from its own copy of the allocation table
// and of the geometry registers. The monitor checks each beat against the oldest
// expected beat. A planning pass at time zero fills a queue of bus operations: item
// beats, register writes, and drain markers that hold the driver until the block is
// idle, so the geometry only ever changes between phases.
module testbench;
	import fcw_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 10;
	localparam int CHAIN_LIMIT  = MAX_CHAIN_DEF;
	localparam int ITEM_TARGET  = 410;
	localparam int PHASES       = 6;
	localparam int SETTLE_GAP   = 8;     // idle cycles after a drain, before register writes
	localparam int END_SETTLE   = 300;   // longer than the slowest walk
	localparam int STALL_LIMIT  = 4000;  // cycles with no beat in or out
	localparam int PRINT_LIMIT  = 50;

	// Index 7 decodes to no register; a write there must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t               kind;
		logic                   calm;    // no random gap before this beat
		logic                   mode;
		logic [CLUSTER_W-1:0]   idx;
		logic [CLUSTER_W-1:0]   val;
		logic [CLUSTER_W-1:0]   first;
		logic [REG_IDX_W-1:0]   reg_idx;
		logic [CFG_W-1:0]       reg_val;
	} walker_op_t;

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [CLUSTER_W-1:0] cluster;
		logic [OFFSET_W-1:0]  offset;
		logic                 last;
	} chain_beat_t;

	// Clock, reset and every block input start at known values.
	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 start         = 1'b0;
	logic                 mode          = MODE_LOAD;
	logic [CLUSTER_W-1:0] entry_index   = '0;
	logic [CLUSTER_W-1:0] entry_value   = '0;
	logic [CLUSTER_W-1:0] head_cluster  = '0;
	logic                 cfg_we        = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index     = REG_SECTOR_BYTES;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 busy;
	logic                 result_valid;
	logic [STATUS_W-1:0]  status;
	logic [CLUSTER_W-1:0] cluster_number;
	logic [OFFSET_W-1:0]  byte_offset;
	logic                 last;

	fat12_cluster_chain_walker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.head_cluster   (head_cluster),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.status         (status),
		.cluster_number (cluster_number),
		.byte_offset    (byte_offset),
		.last           (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Operations waiting for the driver, and beats the block still owes us.
	walker_op_t  walker_ops[$];
	chain_beat_t beats_due[$];

	// Predictor state: table contents and geometry as the block should hold them.
	logic [CLUSTER_W-1:0]  fat_copy [0:FAT_ENTRIES_DEF-1];
	logic [SECTOR_W-1:0]   geo_sector;
	logic [CLUS_SEC_W-1:0] geo_cs;
	logic [RESV_W-1:0]     geo_reserved;
	logic [COPIES_W-1:0]   geo_copies;
	logic [TSEC_W-1:0]     geo_tsec;
	logic [ROOT_W-1:0]     geo_root;

	// Planning state: which table entries the queued loads will have written. A walk
	// is only queued once every entry it will read has been written.
	logic [CLUSTER_W-1:0]  plan_table   [0:FAT_ENTRIES_DEF-1];
	bit                    plan_written [0:FAT_ENTRIES_DEF-1];
	logic [CLUSTER_W-1:0]  plan_starts[$];
	bit                    plan_calm     = 1'b0;
	int                    items_planned = 0;

	// Handshake bookkeeping shared between the monitor and the driver.
	logic        item_taken   = 1'b0;
	int unsigned hold_cnt     = 0;
	int          stall_cycles = 0;
	int          error_count  = 0;
	int          loads_seen   = 0;
	int          walks_seen   = 0;
	int          beats_seen   = 0;

	// One line per mismatch; printing stops after a while but the count keeps going.
	task automatic flag_error(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("ERROR @%0t beat %0d %s: expected 0x%0h, got 0x%0h",
				$realtime, beats_seen, what, want, seen);
	endtask

	// Walks the predicted table from the first cluster and queues the beats the block
	// must produce. A chain stops on an end marker, on a bad or reserved cluster, or
	// once it would go past the chain limit. Both error cases take the place of the
	// last cluster beat when the limit is already full, so a walk never gives more
	// than the limit.
	task automatic predict_walk(input logic [CLUSTER_W-1:0] first);
		chain_beat_t          run[$];
		chain_beat_t          one;
		logic [CLUSTER_W-1:0] cur;
		logic [63:0]          sector_size;
		logic [63:0]          root_sectors;
		logic [63:0]          data_sector;
		bit                   done;

		cur = first;
		done = 1'b0;
		sector_size = 64'(geo_sector);
		root_sectors = 64'd0;
		if (sector_size != 64'd0)
			root_sectors = (64'(geo_root) * 64'd32 + sector_size - 64'd1) / sector_size;
		if (cur >= END_MARK) begin
			one = '{ST_EMPTY, cur, '0, 1'b1};
			run.push_back(one);
			done = 1'b1;
		end
		while (!done) begin
			if (cur >= END_MARK) begin
				run[run.size()-1].last = 1'b1;
				done = 1'b1;
			end else if (cur == BAD_MARK || cur < FIRST_DATA) begin
				if (run.size() >= CHAIN_LIMIT)
					void'(run.pop_back());
				one = '{ST_BAD, cur, '0, 1'b1};
				run.push_back(one);
				done = 1'b1;
			end else if (run.size() >= CHAIN_LIMIT) begin
				void'(run.pop_back());
				one = '{ST_LONG, cur, '0, 1'b1};
				run.push_back(one);
				done = 1'b1;
			end else begin
				data_sector = 64'(geo_reserved) + 64'(geo_copies) * 64'(geo_tsec)
					+ root_sectors + (64'(cur) - 64'(FIRST_DATA)) * 64'(geo_cs);
				one = '{ST_CLUSTER, cur, OFFSET_W'(data_sector * sector_size), 1'b0};
				run.push_back(one);
				cur = fat_copy[cur];
			end
		end
		foreach (run[k])
			beats_due.push_back(run[k]);
	endtask

	// Monitor. Everything is sampled at the rising edge, where the handshake takes
	// effect. Result beats are checked before the prediction for a walk accepted at
	// the same edge is queued, since such a beat can only belong to an older walk.
	always @(posedge clk) begin : watch
		chain_beat_t want;

		if (!arst_n) begin
			geo_sector   = SECTOR_BYTES_RST;
			geo_cs       = CLUSTER_SECTORS_RST;
			geo_reserved = RESERVED_COUNT_RST;
			geo_copies   = TABLE_COPIES_RST;
			geo_tsec     = TABLE_SECTORS_RST;
			geo_root     = ROOT_ENTRIES_RST;
			item_taken   <= 1'b0;
			stall_cycles <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SECTOR_BYTES:    geo_sector   = cfg_data[SECTOR_W-1:0];
					REG_CLUSTER_SECTORS: geo_cs       = cfg_data[CLUS_SEC_W-1:0];
					REG_RESERVED_COUNT:  geo_reserved = cfg_data[RESV_W-1:0];
					REG_TABLE_COPIES:    geo_copies   = cfg_data[COPIES_W-1:0];
					REG_TABLE_SECTORS:   geo_tsec     = cfg_data[TSEC_W-1:0];
					REG_ROOT_ENTRIES:    geo_root     = cfg_data[ROOT_W-1:0];
					default: ;
				endcase
			end

			if (result_valid) begin
				beats_seen++;
				if (beats_due.size() == 0) begin
					flag_error("beat with nothing outstanding, cluster", '0,
						32'(cluster_number));
				end else begin
					want = beats_due.pop_front();
					if (status !== want.status)
						flag_error("status", 32'(want.status), 32'(status));
					if (cluster_number !== want.cluster)
						flag_error("cluster_number", 32'(want.cluster), 32'(cluster_number));
					if (byte_offset !== want.offset)
						flag_error("byte_offset", want.offset, byte_offset);
					if (last !== want.last)
						flag_error("last", 32'(want.last), 32'(last));
				end
			end

			// The item beat is taken here: update the table copy or predict the walk.
			if (start && !busy) begin
				if (mode == MODE_LOAD) begin
					loads_seen++;
					fat_copy[entry_index] = entry_value;
				end else begin
					walks_seen++;
					predict_walk(head_cluster);
				end
			end

			item_taken <= start && !busy;
			if ((start && !busy) || result_valid || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Driver. Inputs change on the falling edge. Start stays high until the block
	// takes the beat; the next beat may follow straight away, so start is computed
	// once per edge and assigned once. About one try in ten, a waiting item is held
	// back, except during the calm stretch.
	always @(negedge clk) begin : feed
		walker_op_t op;
		logic       raise;
		logic       write;

		raise = start && !item_taken;
		write = 1'b0;
		if (arst_n && !raise) begin
			if (hold_cnt != 0) begin
				hold_cnt--;
			end else if (walker_ops.size() != 0) begin
				op = walker_ops[0];
				case (op.kind)
					OP_DRAIN: begin
						// Registers change only once the block owes nothing and is idle.
						if (beats_due.size() == 0 && !busy) begin
							void'(walker_ops.pop_front());
							hold_cnt = SETTLE_GAP;
						end
					end
					OP_CFG: begin
						void'(walker_ops.pop_front());
						cfg_index <= op.reg_idx;
						cfg_data  <= op.reg_val;
						write = 1'b1;
					end
					default: begin
						if (op.calm || $urandom_range(99, 0) >= 10) begin
							void'(walker_ops.pop_front());
							mode          <= op.mode;
							entry_index   <= op.idx;
							entry_value   <= op.val;
							head_cluster  <= op.first;
							raise = 1'b1;
						end
					end
				endcase
			end
		end
		start  <= raise;
		cfg_we <= write;
	end

	// Planning helpers. The unused fields of an item get random values so that every
	// input bit moves.
	task automatic add_item(input logic m, input logic [CLUSTER_W-1:0] idx,
			input logic [CLUSTER_W-1:0] val, input logic [CLUSTER_W-1:0] first);
		walker_op_t op;

		op = '{OP_ITEM, plan_calm, m, idx, val, first, REG_SECTOR_BYTES, '0};
		walker_ops.push_back(op);
		items_planned++;
	endtask

	task automatic plan_load(input logic [CLUSTER_W-1:0] idx,
			input logic [CLUSTER_W-1:0] val);
		add_item(MODE_LOAD, idx, val, CLUSTER_W'($urandom));
		plan_table[idx] = val;
		plan_written[idx] = 1'b1;
	endtask

	// Mostly end markers; sometimes the bad marker or one of the reserved clusters.
	function automatic logic [CLUSTER_W-1:0] chain_tail();
		int pick;

		pick = $urandom_range(99, 0);
		if (pick < 70)
			return CLUSTER_W'($urandom_range(12'hFFF, END_MARK));
		if (pick < 85)
			return BAD_MARK;
		return CLUSTER_W'($urandom_range(1, 0));
	endfunction

	// Follows the planned table from the first cluster and fills any entry that the
	// walk would read but nobody wrote yet, then queues the walk itself.
	task automatic plan_walk(input logic [CLUSTER_W-1:0] first);
		logic [CLUSTER_W-1:0] c;
		int                   steps;

		c = first;
		steps = 0;
		while (c >= FIRST_DATA && c < BAD_MARK && steps < CHAIN_LIMIT) begin
			if (!plan_written[c])
				plan_load(c, chain_tail());
			c = plan_table[c];
			steps++;
		end
		add_item(MODE_WALK, CLUSTER_W'($urandom), CLUSTER_W'($urandom), first);
	endtask

	// A well-formed chain of random clusters, its tail, and a walk over it.
	task automatic plan_chain(input int len, input logic [CLUSTER_W-1:0] tail);
		logic [CLUSTER_W-1:0] first;
		logic [CLUSTER_W-1:0] c;
		logic [CLUSTER_W-1:0] nxt;

		first = CLUSTER_W'($urandom_range(BAD_MARK - 1, FIRST_DATA));
		c = first;
		for (int i = 1; i < len; i++) begin
			nxt = CLUSTER_W'($urandom_range(BAD_MARK - 1, FIRST_DATA));
			plan_load(c, nxt);
			c = nxt;
		end
		plan_load(c, tail);
		plan_starts.push_back(first);
		plan_walk(first);
	endtask

	task automatic plan_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		walker_op_t op;

		op = '{OP_CFG, 1'b1, MODE_LOAD, '0, '0, '0, idx, val};
		walker_ops.push_back(op);
	endtask

	// Waits for the block to drain, then writes all six geometry registers.
	task automatic plan_geometry(input logic [CFG_W-1:0] sb, input logic [CFG_W-1:0] cs,
			input logic [CFG_W-1:0] rc, input logic [CFG_W-1:0] tc,
			input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] re);
		walker_op_t op;

		op = '{OP_DRAIN, 1'b1, MODE_LOAD, '0, '0, '0, REG_SECTOR_BYTES, '0};
		walker_ops.push_back(op);
		plan_reg(REG_SECTOR_BYTES, sb);
		plan_reg(REG_CLUSTER_SECTORS, cs);
		plan_reg(REG_RESERVED_COUNT, rc);
		plan_reg(REG_TABLE_COPIES, tc);
		plan_reg(REG_TABLE_SECTORS, ts);
		plan_reg(REG_ROOT_ENTRIES, re);
	endtask

	// Random mix up to the item goal: mostly fresh chains with random content, some
	// chains that run into the last chain, walks over whatever the table holds by
	// now, walks from marker values, and stray loads that may cut into old chains.
	task automatic plan_mixed(input int goal);
		int pick;

		while (items_planned < goal) begin
			pick = $urandom_range(99, 0);
			if (pick < 50)
				plan_chain($urandom_range(8, 1), chain_tail());
			else if (pick < 55)
				plan_chain($urandom_range(6, 1), plan_starts.size() != 0 ?
					plan_starts[plan_starts.size()-1] : FIRST_DATA);
			else if (pick < 65)
				plan_walk(CLUSTER_W'($urandom));
			else if (pick < 72)
				plan_walk(CLUSTER_W'($urandom_range(12'hFFF, BAD_MARK)));
			else if (pick < 75)
				plan_walk(CLUSTER_W'($urandom_range(1, 0)));
			else if (pick < 88)
				plan_load(CLUSTER_W'($urandom), CLUSTER_W'($urandom));
			else if (plan_starts.size() != 0)
				plan_walk(plan_starts[$urandom_range(plan_starts.size() - 1, 0)]);
		end
	endtask

	// Watchdog: a long spell with no beat in either direction means a hang.
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : plan_and_run
		int goal;

		for (int i = 0; i < FAT_ENTRIES_DEF; i++) begin
			plan_table[i] = '0;
			plan_written[i] = 1'b0;
		end

		// Directed part at the reset geometry. Loads at both ends of the index and
		// value ranges, then a single-cluster chain on the first data cluster.
		plan_load(12'h000, 12'h000);
		plan_load(12'hFFF, 12'hFFF);
		plan_load(FIRST_DATA, END_MARK);
		plan_walk(FIRST_DATA);
		// Starts at the end marker give an empty chain; starts at the bad marker or at
		// a reserved cluster fail at once.
		plan_walk(END_MARK);
		plan_walk(12'hFFF);
		plan_walk(BAD_MARK);
		plan_walk(12'h000);
		plan_walk(12'h001);
		// A bad cluster after two good ones, and chains that run into reserved clusters.
		plan_load(12'd3, 12'd4);
		plan_load(12'd4, BAD_MARK);
		plan_walk(12'd3);
		plan_load(12'd5, 12'h000);
		plan_walk(12'd5);
		plan_load(12'd7, 12'h001);
		plan_walk(12'd7);
		// A cluster that points to itself and a two-cluster loop: both overflow.
		plan_load(12'd6, 12'd6);
		plan_walk(12'd6);
		plan_load(12'd8, 12'd9);
		plan_load(12'd9, 12'd8);
		plan_walk(12'd8);
		// The highest usable cluster gives the largest offset.
		plan_load(BAD_MARK - 1, 12'hFFF);
		plan_walk(BAD_MARK - 1);

		// Random part, one geometry per phase: low ends, high ends, a zero sector
		// size with every other register saturated, a setting whose offsets wrap
		// past 32 bits, zero sectors per cluster, and a random legal volume.
		for (int p = 0; p < PHASES; p++) begin
			goal = items_planned + (ITEM_TARGET - items_planned) / (PHASES - p);
			plan_calm = (p == 1);
			case (p)
				0: plan_geometry(16'd512, 16'd1, 16'd1, 16'd1, 16'd1, 16'd16);
				1: plan_geometry(16'd4096, 16'd128, 16'd65535, 16'd4, 16'd255, 16'd4096);
				2: begin
					plan_geometry(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					plan_reg(REG_SPARE, CFG_W'($urandom));
				end
				3: plan_geometry(16'h1FFF, 16'd255, CFG_W'($urandom), 16'd0, 16'd0, 16'd0);
				4: plan_geometry(CFG_W'($urandom_range(4096, 512)), 16'd0, CFG_W'($urandom),
					CFG_W'($urandom_range(4, 1)), CFG_W'($urandom_range(255, 1)),
					CFG_W'($urandom_range(4096, 16)));
				default: plan_geometry(CFG_W'($urandom_range(4096, 512)),
					CFG_W'($urandom_range(128, 1)), CFG_W'($urandom_range(65535, 1)),
					CFG_W'($urandom_range(4, 1)), CFG_W'($urandom_range(255, 1)),
					CFG_W'($urandom_range(4096, 16)));
			endcase
			// A chain of exactly the limit ends cleanly on its last cluster; one of the
			// limit followed by a bad cluster has the error replace its last beat.
			if (p == 0)
				plan_chain(CHAIN_LIMIT, END_MARK);
			if (p == 1)
				plan_chain(CHAIN_LIMIT, BAD_MARK);
			plan_mixed(goal);
		end
		plan_calm = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every beat has gone in, every result has come out, and then a
		// little longer so that a stray extra beat would still be caught.
		while (walker_ops.size() != 0 || start)
			@(posedge clk);
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (beats_due.size() != 0)
			flag_error("beats never delivered", '0, 32'(beats_due.size()));

		$display("Ran %0d table loads and %0d chain walks over %0d volume geometries,",
			loads_seen, walks_seen, PHASES + 1);
		$display("checking %0d result beats; %0d mismatches.", beats_seen, error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
